FILE: src/chassis_wheel_kinematics_odometry_defines.svh
// assertion macros shared by the chassis kinematics block
`ifndef CHASSIS_WHEEL_KINEMATICS_ODOMETRY_DEFINES_SVH
`define CHASSIS_WHEEL_KINEMATICS_ODOMETRY_DEFINES_SVH
// same-cycle implication, sampled on clk, off while rst_n is low
`define CWKO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chassis kinematics check failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define CWKO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chassis kinematics check failed");
`endif

FILE: src/cwko_pkg.sv
// shared types and constants of the chassis kinematics block
package cwko_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;

  // sqrt2/2 and pi/30 in Q2.30
  localparam longint HALF_SQRT2_Q30 = 64'sd759250125;
  localparam longint PI_OVER_30_Q30 = 64'sd112441981;

  // register indexes
  localparam logic [2:0] REG_KIND = 3'd0;
  localparam logic [2:0] REG_MAXX = 3'd1;
  localparam logic [2:0] REG_MAXY = 3'd2;
  localparam logic [2:0] REG_MAXW = 3'd3;
  localparam logic [2:0] REG_DIAM = 3'd4;
  localparam logic [2:0] REG_GEOM = 3'd5;
  localparam logic [2:0] REG_RATE = 3'd6;

  // configuration as seen by the datapath
  typedef struct packed {
    logic        kind;
    logic [30:0] max_x;
    logic [30:0] max_y;
    logic [30:0] max_w;
    logic [30:0] diam;
    logic [30:0] geom;
    logic [16:0] rate;
  } cfg_t;

  // status of the serial scale unit
  typedef struct packed {
    logic busy;
    logic done;
  } sc_status_t;

  typedef enum logic [1:0] {SC_IDLE, SC_MUL, SC_DIV, SC_FIN} sc_state_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT} st_state_t;

  // operation sequence of one tick
  typedef enum logic [4:0] {
    S_AV0, S_AV1, S_AV2, S_AV3, S_WT, S_CX, S_CY,
    S_T0, S_T1, S_T2, S_T3, S_V0A, S_V0B, S_V1A, S_V1B, S_V2,
    S_D0, S_A0, S_D1, S_A1, S_D2, S_A2
  } step_t;

endpackage

FILE: src/cwko_cfg.sv
// apb register file of the chassis kinematics block
module cwko_cfg #(
  parameter int DW = cwko_pkg::DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cwko_pkg::cfg_t      cfg
);

  localparam longint DMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;

  cwko_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  // saturate a 31-bit register value to the data range
  function automatic logic [30:0] sat31(input logic [30:0] v);
    if (longint'({33'd0, v}) > DMAX) return 31'(DMAX);
    return v;
  endfunction

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind  <= 1'b0;
      cfg_r.max_x <= sat31(31'd196608);
      cfg_r.max_y <= sat31(31'd196608);
      cfg_r.max_w <= sat31(31'd393216);
      cfg_r.diam  <= sat31(31'd9830);
      cfg_r.geom  <= sat31(31'd52429);
      cfg_r.rate  <= 17'd1000;
    end else if (wr) begin
      case (idx)
        cwko_pkg::REG_KIND: cfg_r.kind  <= pwdata[0];
        cwko_pkg::REG_MAXX: cfg_r.max_x <= sat31(pwdata[30:0]);
        cwko_pkg::REG_MAXY: cfg_r.max_y <= sat31(pwdata[30:0]);
        cwko_pkg::REG_MAXW: cfg_r.max_w <= sat31(pwdata[30:0]);
        cwko_pkg::REG_DIAM: cfg_r.diam  <= sat31(pwdata[30:0]);
        cwko_pkg::REG_GEOM: cfg_r.geom  <= sat31(pwdata[30:0]);
        cwko_pkg::REG_RATE: cfg_r.rate  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      cwko_pkg::REG_KIND: prdata = {31'd0, cfg_r.kind};
      cwko_pkg::REG_MAXX: prdata = {1'b0, cfg_r.max_x};
      cwko_pkg::REG_MAXY: prdata = {1'b0, cfg_r.max_y};
      cwko_pkg::REG_MAXW: prdata = {1'b0, cfg_r.max_w};
      cwko_pkg::REG_DIAM: prdata = {1'b0, cfg_r.diam};
      cwko_pkg::REG_GEOM: prdata = {1'b0, cfg_r.geom};
      cwko_pkg::REG_RATE: prdata = {15'd0, cfg_r.rate};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/cwko_scale.sv
// bit-serial a*b/c unit: shift-add multiply, restoring divide, saturation
module cwko_scale #(
  parameter int DW = cwko_pkg::DATA_WIDTH,
  parameter int OW = cwko_pkg::DATA_WIDTH + 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [OW-1:0]    a,
  input  logic signed [OW-1:0]    b,
  input  logic signed [OW-1:0]    c,
  output logic signed [DW-1:0]    res,
  output cwko_pkg::sc_status_t    st
);

  localparam int PW = 2 * OW;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);

  cwko_pkg::sc_state_t state_r, state_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [OW-1:0] ma_r, ma_nxt, mc_r, mc_nxt, rem_r, rem_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [OW:0]   sum, sh, diff;
  logic          a_sign_r;

  function automatic logic [OW-1:0] mag(input logic signed [OW-1:0] v);
    return v[OW-1] ? OW'(-v) : OW'(v);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cwko_pkg::SC_IDLE: if (start) state_nxt = cwko_pkg::SC_MUL;
      cwko_pkg::SC_MUL:
        if (cnt_r == CW'(OW - 1))
          state_nxt = (mc_r == '0) ? cwko_pkg::SC_FIN : cwko_pkg::SC_DIV;
      cwko_pkg::SC_DIV:  if (cnt_r == CW'(PW - 1)) state_nxt = cwko_pkg::SC_FIN;
      cwko_pkg::SC_FIN:  state_nxt = cwko_pkg::SC_IDLE;
      default:           state_nxt = cwko_pkg::SC_IDLE;
    endcase
  end

  // datapath: one multiplier bit or one quotient bit per cycle
  always_comb begin
    acc_nxt = acc_r;
    ma_nxt  = ma_r;
    mc_nxt  = mc_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    sum     = {1'b0, acc_r[PW-1:OW]} + (acc_r[0] ? {1'b0, ma_r} : '0);
    sh      = {rem_r, acc_r[PW-1]};
    diff    = sh - {1'b0, mc_r};
    case (state_r)
      cwko_pkg::SC_IDLE: begin
        if (start) begin
          ma_nxt  = mag(a);
          mc_nxt  = mag(c);
          acc_nxt = {{OW{1'b0}}, mag(b)};
          neg_nxt = a[OW-1] ^ b[OW-1] ^ c[OW-1];
          cnt_nxt = '0;
        end
      end
      cwko_pkg::SC_MUL: begin
        acc_nxt = {sum, acc_r[OW-1:1]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(OW - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          // zero divisor: saturate toward the sign of the product
          if (mc_r == '0) begin
            neg_nxt = a_sign_r;
            acc_nxt = ({sum, acc_r[OW-1:1]} == '0) ? '0 : '1;
          end
        end
      end
      cwko_pkg::SC_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (!diff[OW]) begin
          rem_nxt = diff[OW-1:0];
          acc_nxt = {acc_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = sh[OW-1:0];
          acc_nxt = {acc_r[PW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // sign of a*b, kept for the zero divisor case
  always_ff @(posedge clk) begin
    if (state_r == cwko_pkg::SC_IDLE && start) a_sign_r <= a[OW-1] ^ b[OW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwko_pkg::SC_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
    mc_r  <= mc_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // saturate the quotient to the data range
  always_comb begin
    if (acc_r > LIM || (acc_r == LIM && !neg_r))
      res = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else
      res = neg_r ? DW'(-acc_r) : DW'(acc_r);
  end

  assign st.busy = (state_r != cwko_pkg::SC_IDLE);
  assign st.done = (state_r == cwko_pkg::SC_FIN);

endmodule

FILE: src/chassis_wheel_kinematics_odometry.sv
// Chassis wheel kinematics and odometry, one control tick per input item,
// four result items per tick (slots 0 to 3). All the multiply and divide
// work of a tick runs as 22 operations a*b/c on one shared bit-serial unit:
// each is issued, then runs its shift-add multiply steps, its restoring
// divide steps (skipped for a zero divisor) and a finish step. The block
// takes a new item once the four results of the previous one have been
// taken. Registers sit on an APB port at 4*index.
module chassis_wheel_kinematics_odometry #(
  parameter int FRAC_BITS  = cwko_pkg::FRAC_BITS,
  parameter int DATA_WIDTH = cwko_pkg::DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_w,
  input  logic signed [15:0] in_rpm_wheel0,
  input  logic signed [15:0] in_rpm_wheel1,
  input  logic signed [15:0] in_rpm_wheel2,
  input  logic signed [15:0] in_rpm_wheel3,
  input  logic [15:0]        in_elapsed_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_slot,
  output logic signed [31:0] out_wheel_target_speed,
  output logic signed [31:0] out_axis_velocity,
  output logic signed [31:0] out_axis_displacement,
  output logic signed [31:0] out_axis_acceleration,
  output logic               out_last_result
);

`include "chassis_wheel_kinematics_odometry_defines.svh"

  localparam int DW = DATA_WIDTH;
  localparam int OW = DATA_WIDTH + 4;
  localparam longint DMAX  = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam longint DMIN  = -DMAX - 64'sd1;
  localparam longint CQ    = (cwko_pkg::HALF_SQRT2_Q30 + (64'sd1 <<< (29 - FRAC_BITS)))
                             >>> (30 - FRAC_BITS);
  localparam logic signed [OW-1:0] ONE_O = OW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [OW-1:0] C_O   = OW'(CQ);
  localparam logic signed [OW-1:0] PI_O  = OW'(cwko_pkg::PI_OVER_30_Q30);
  localparam logic signed [OW-1:0] PID_O = OW'(64'sd1 <<< (30 - FRAC_BITS));

  cwko_pkg::cfg_t       cfg;
  cwko_pkg::sc_status_t sc_st;
  cwko_pkg::st_state_t  state_r, state_nxt;
  cwko_pkg::step_t      step_r, step_nxt;
  logic [1:0]           slot_r, slot_nxt;
  logic                 sc_start;
  logic signed [OW-1:0] op_a, op_b, op_c;
  logic signed [DW-1:0] sc_res;

  logic signed [DW-1:0] x_r, y_r, w_r, wt_r, cx_r, cy_r, tmp_r;
  logic signed [DW-1:0] av_r [4];
  logic signed [DW-1:0] tgt_r [4];
  logic signed [DW-1:0] vel_r [3];
  logic signed [DW-1:0] prev_r [3];
  logic signed [DW-1:0] disp_r [3];
  logic signed [DW-1:0] acc_r [3];
  logic signed [15:0]   rpm_r [4];
  logic [15:0]          ticks_r;

  logic signed [OW-1:0] ea0, ea1, ea2, ea3, ex, ey, ewt, ecx, ecy, diam_o, geom_o, rate_o;
  logic signed [OW-1:0] n0, n1, n2, n3, sum4;
  logic signed [DW:0]   disp_sum;
  logic                 in_acc, out_acc;
  logic [1:0]           vk;

  cwko_cfg #(.DW(DW)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cwko_scale #(.DW(DW), .OW(OW)) u_scale (
    .clk, .rst_n, .start(sc_start), .a(op_a), .b(op_b), .c(op_c), .res(sc_res), .st(sc_st)
  );

  // saturate a 32-bit input to the data range, then clamp to the limit
  function automatic logic signed [DW-1:0] clamp_in(input logic signed [31:0] v,
                                                    input logic [30:0] m);
    longint vv, mm;
    vv = longint'(v);
    mm = longint'({33'd0, m});
    if (vv > DMAX) vv = DMAX;
    if (vv < DMIN) vv = DMIN;
    if (vv > mm) vv = mm;
    if (vv < -mm) vv = -mm;
    return DW'(vv);
  endfunction

  function automatic logic signed [OW-1:0] ext(input logic signed [DW-1:0] v);
    return OW'(v);
  endfunction

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // operand sums
  assign ea0    = ext(av_r[0]);
  assign ea1    = ext(av_r[1]);
  assign ea2    = ext(av_r[2]);
  assign ea3    = ext(av_r[3]);
  assign ex     = ext(x_r);
  assign ey     = ext(y_r);
  assign ewt    = ext(wt_r);
  assign ecx    = ext(cx_r);
  assign ecy    = ext(cy_r);
  assign diam_o = OW'({1'b0, cfg.diam});
  assign geom_o = OW'({1'b0, cfg.geom});
  assign rate_o = (cfg.rate == '0) ? OW'(1) : OW'({1'b0, cfg.rate});
  assign sum4   = ea0 + ea1 + ea2 + ea3;
  assign n0 = cfg.kind ? (-ecx - ecy - ewt) : (-ey - ex - ewt);
  assign n1 = cfg.kind ? (-ecx + ecy - ewt) : (ey - ex - ewt);
  assign n2 = cfg.kind ? (ecx + ecy - ewt)  : (ey + ex - ewt);
  assign n3 = cfg.kind ? (ecx - ecy - ewt)  : (-ey + ex - ewt);

  // axis of the odometry steps
  always_comb begin
    case (step_r)
      cwko_pkg::S_D1, cwko_pkg::S_A1: vk = 2'd1;
      cwko_pkg::S_D2, cwko_pkg::S_A2: vk = 2'd2;
      default:                        vk = 2'd0;
    endcase
  end

  // operand selection for the current step
  always_comb begin
    op_a = ext(vel_r[vk]);
    op_b = OW'({1'b0, ticks_r});
    op_c = rate_o;
    case (step_r)
      cwko_pkg::S_AV0: begin op_a = OW'(rpm_r[0]); op_b = PI_O; op_c = PID_O; end
      cwko_pkg::S_AV1: begin op_a = OW'(rpm_r[1]); op_b = PI_O; op_c = PID_O; end
      cwko_pkg::S_AV2: begin op_a = OW'(rpm_r[2]); op_b = PI_O; op_c = PID_O; end
      cwko_pkg::S_AV3: begin op_a = OW'(rpm_r[3]); op_b = PI_O; op_c = PID_O; end
      cwko_pkg::S_WT: begin
        op_a = ext(w_r); op_b = geom_o; op_c = cfg.kind ? ONE_O : (ONE_O <<< 1);
      end
      cwko_pkg::S_CX: begin op_a = C_O; op_b = ex; op_c = ONE_O; end
      cwko_pkg::S_CY: begin op_a = C_O; op_b = ey; op_c = ONE_O; end
      cwko_pkg::S_T0: begin op_a = n0; op_b = ONE_O <<< 1; op_c = diam_o; end
      cwko_pkg::S_T1: begin op_a = n1; op_b = ONE_O <<< 1; op_c = diam_o; end
      cwko_pkg::S_T2: begin op_a = n2; op_b = ONE_O <<< 1; op_c = diam_o; end
      cwko_pkg::S_T3: begin op_a = n3; op_b = ONE_O <<< 1; op_c = diam_o; end
      cwko_pkg::S_V0A: begin
        op_a = cfg.kind ? -(ea2 + ea3 - ea0 - ea1) : (ea2 + ea3 - ea1 - ea0);
        op_b = diam_o; op_c = cfg.kind ? (ONE_O <<< 2) : (ONE_O <<< 3);
      end
      cwko_pkg::S_V1A: begin
        op_a = ea1 + ea2 - ea0 - ea3;
        op_b = diam_o; op_c = cfg.kind ? (ONE_O <<< 2) : (ONE_O <<< 3);
      end
      cwko_pkg::S_V0B, cwko_pkg::S_V1B: begin
        op_a = ext(tmp_r); op_b = cfg.kind ? C_O : ONE_O; op_c = ONE_O;
      end
      cwko_pkg::S_V2: begin
        op_a = -sum4; op_b = diam_o; op_c = cfg.kind ? (geom_o <<< 3) : (geom_o <<< 2);
      end
      cwko_pkg::S_A0, cwko_pkg::S_A1, cwko_pkg::S_A2: begin
        op_a = ext(vel_r[vk]) - ext(prev_r[vk]);
        op_b = rate_o; op_c = OW'({1'b0, ticks_r});
      end
      default: ;
    endcase
  end

  // next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    slot_nxt  = slot_r;
    case (state_r)
      cwko_pkg::ST_IDLE: if (in_acc) begin
        state_nxt = cwko_pkg::ST_ISSUE;
        step_nxt  = cwko_pkg::S_AV0;
      end
      cwko_pkg::ST_ISSUE: state_nxt = cwko_pkg::ST_WAIT;
      cwko_pkg::ST_WAIT: if (sc_st.done) begin
        if (step_r == cwko_pkg::S_A2) begin
          state_nxt = cwko_pkg::ST_EMIT;
          slot_nxt  = 2'd0;
        end else begin
          state_nxt = cwko_pkg::ST_ISSUE;
          step_nxt  = cwko_pkg::step_t'(step_r + 5'd1);
        end
      end
      cwko_pkg::ST_EMIT: if (out_acc) begin
        if (slot_r == 2'd3) state_nxt = cwko_pkg::ST_IDLE;
        else slot_nxt = slot_r + 2'd1;
      end
      default: state_nxt = cwko_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state_r == cwko_pkg::ST_IDLE);
    sc_start  = (state_r == cwko_pkg::ST_ISSUE);
    out_valid = (state_r == cwko_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwko_pkg::ST_IDLE;
      step_r  <= cwko_pkg::S_AV0;
      slot_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= clamp_in(in_target_x, cfg.max_x);
      y_r      <= clamp_in(in_target_y, cfg.max_y);
      w_r      <= clamp_in(in_target_w, cfg.max_w);
      rpm_r[0] <= in_rpm_wheel0;
      rpm_r[1] <= in_rpm_wheel1;
      rpm_r[2] <= in_rpm_wheel2;
      rpm_r[3] <= in_rpm_wheel3;
      ticks_r  <= in_elapsed_ticks;
    end
  end

  // saturating displacement update
  assign disp_sum = (DW+1)'(disp_r[vk]) + (DW+1)'(sc_res);

  // result write-back, odometry state cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
        disp_r[i] <= '0;
      end
    end else if (state_r == cwko_pkg::ST_WAIT && sc_st.done) begin
      case (step_r)
        cwko_pkg::S_D0, cwko_pkg::S_D1, cwko_pkg::S_D2: begin
          if (disp_sum[DW] != disp_sum[DW-1])
            disp_r[vk] <= disp_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
          else
            disp_r[vk] <= disp_sum[DW-1:0];
        end
        cwko_pkg::S_A0, cwko_pkg::S_A1, cwko_pkg::S_A2: prev_r[vk] <= vel_r[vk];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cwko_pkg::ST_WAIT && sc_st.done) begin
      case (step_r)
        cwko_pkg::S_AV0: av_r[0] <= sc_res;
        cwko_pkg::S_AV1: av_r[1] <= sc_res;
        cwko_pkg::S_AV2: av_r[2] <= sc_res;
        cwko_pkg::S_AV3: av_r[3] <= sc_res;
        cwko_pkg::S_WT:  wt_r <= sc_res;
        cwko_pkg::S_CX:  cx_r <= sc_res;
        cwko_pkg::S_CY:  cy_r <= sc_res;
        cwko_pkg::S_T0:  tgt_r[0] <= sc_res;
        cwko_pkg::S_T1:  tgt_r[1] <= sc_res;
        cwko_pkg::S_T2:  tgt_r[2] <= sc_res;
        cwko_pkg::S_T3:  tgt_r[3] <= sc_res;
        cwko_pkg::S_V0A, cwko_pkg::S_V1A: tmp_r <= sc_res;
        cwko_pkg::S_V0B: vel_r[0] <= sc_res;
        cwko_pkg::S_V1B: vel_r[1] <= sc_res;
        cwko_pkg::S_V2:  vel_r[2] <= sc_res;
        cwko_pkg::S_A0, cwko_pkg::S_A1, cwko_pkg::S_A2:
          acc_r[vk] <= (ticks_r == '0) ? '0 : sc_res;
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    out_slot               = slot_r;
    out_last_result        = (slot_r == 2'd3);
    out_wheel_target_speed = 32'(tgt_r[slot_r]);
    if (slot_r == 2'd3) begin
      out_axis_velocity     = '0;
      out_axis_displacement = '0;
      out_axis_acceleration = '0;
    end else begin
      out_axis_velocity     = 32'(vel_r[slot_r]);
      out_axis_displacement = 32'(disp_r[slot_r]);
      out_axis_acceleration = 32'(acc_r[slot_r]);
    end
  end

  `CWKO_ASSERT_IMP(a_start_idle, sc_start, !sc_st.busy)
  `CWKO_ASSERT_IMP(a_no_overlap, out_valid, !in_ready && !sc_st.busy)
  `CWKO_ASSERT_NXT(a_last_frees, out_acc && out_last_result, in_ready && !out_valid)
  `CWKO_ASSERT_NXT(a_accept_issue, in_acc, sc_start && step_r == cwko_pkg::S_AV0)

endmodule

FILE: dv/chassis_wheel_kinematics_odometry_tb.sv
// testbench for the chassis wheel kinematics and odometry block
`timescale 1ns / 100ps

module chassis_wheel_kinematics_odometry_tb;

  localparam int  N_RANDOM = 150;
  localparam real HALF_PERIOD = 6.0;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tw;
    logic signed [15:0] rpm0;
    logic signed [15:0] rpm1;
    logic signed [15:0] rpm2;
    logic signed [15:0] rpm3;
    logic [15:0]        ticks;
  } tick_item_t;

  typedef struct packed {
    logic [1:0]         slot;
    logic signed [31:0] wheel_speed;
    logic signed [31:0] velocity;
    logic signed [31:0] displacement;
    logic signed [31:0] acceleration;
    logic               last;
  } wheel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  tick_item_t drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_slot;
  logic signed [31:0] out_wheel_target_speed, out_axis_velocity;
  logic signed [31:0] out_axis_displacement, out_axis_acceleration;
  logic out_last_result;

  // predictor state and its copy of the registers
  logic        chassis_omni;
  longint      lim_x, lim_y, lim_w, diam, geom, rate;
  longint      prev_vel [3];
  longint      disp_sum [3];

  tick_item_t    pending_items [$];
  wheel_result_t expected_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit hold_off = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  always #(HALF_PERIOD) clk = ~clk;

  chassis_wheel_kinematics_odometry i_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready,
    .in_target_x(drv.tx), .in_target_y(drv.ty), .in_target_w(drv.tw),
    .in_rpm_wheel0(drv.rpm0), .in_rpm_wheel1(drv.rpm1),
    .in_rpm_wheel2(drv.rpm2), .in_rpm_wheel3(drv.rpm3),
    .in_elapsed_ticks(drv.ticks),
    .out_valid, .out_ready, .out_slot, .out_wheel_target_speed,
    .out_axis_velocity, .out_axis_displacement, .out_axis_acceleration,
    .out_last_result
  );

  function automatic longint clip(longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  // a*b/c truncated toward zero, saturated to 32 bits
  function automatic longint muldiv(longint a, longint b, longint c);
    logic neg;
    logic [127:0] prod, quot;
    logic [63:0] ma, mb, mc;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    prod = {64'd0, ma} * {64'd0, mb};
    if (mc == 0) begin
      if (prod == 0) return 0;
      return ((a < 0) != (b < 0)) ? QMIN : QMAX;
    end
    quot = prod / {64'd0, mc};
    if (quot > 128'd2147483648) return neg ? QMIN : QMAX;
    if (neg) return -longint'(quot[63:0]);
    return quot > 128'd2147483647 ? QMAX : longint'(quot[63:0]);
  endfunction

  function automatic longint clamp_mag(longint v, longint m);
    return v > m ? m : (v < -m ? -m : v);
  endfunction

  // expected four results of one control tick
  task automatic predict_tick(input tick_item_t it);
    longint x, y, w, t, r, c, wt, cx, cy;
    longint av [4];
    longint n [4];
    longint vel [3];
    longint acc [3];
    wheel_result_t res;
    x = clamp_mag(longint'(it.tx), lim_x);
    y = clamp_mag(longint'(it.ty), lim_y);
    w = clamp_mag(longint'(it.tw), lim_w);
    t = longint'(it.ticks);
    r = rate == 0 ? 1 : rate;
    c = (cwko_pkg::HALF_SQRT2_Q30 + (64'sd1 <<< (29 - cwko_pkg::FRAC_BITS)))
        >>> (30 - cwko_pkg::FRAC_BITS);
    av[0] = muldiv(longint'(it.rpm0), cwko_pkg::PI_OVER_30_Q30,
                   64'sd1 <<< (30 - cwko_pkg::FRAC_BITS));
    av[1] = muldiv(longint'(it.rpm1), cwko_pkg::PI_OVER_30_Q30,
                   64'sd1 <<< (30 - cwko_pkg::FRAC_BITS));
    av[2] = muldiv(longint'(it.rpm2), cwko_pkg::PI_OVER_30_Q30,
                   64'sd1 <<< (30 - cwko_pkg::FRAC_BITS));
    av[3] = muldiv(longint'(it.rpm3), cwko_pkg::PI_OVER_30_Q30,
                   64'sd1 <<< (30 - cwko_pkg::FRAC_BITS));
    if (!chassis_omni) begin
      wt = muldiv(w, geom, 2 * 65536);
      n[0] = -y - x - wt;
      n[1] = y - x - wt;
      n[2] = y + x - wt;
      n[3] = -y + x - wt;
      vel[0] = muldiv(av[2] + av[3] - av[1] - av[0], diam, 8 * 65536);
      vel[1] = muldiv(av[1] + av[2] - av[0] - av[3], diam, 8 * 65536);
      vel[2] = muldiv(-(av[0] + av[1] + av[2] + av[3]), diam, 4 * geom);
    end else begin
      cx = muldiv(c, x, 65536);
      cy = muldiv(c, y, 65536);
      wt = muldiv(w, geom, 65536);
      n[0] = -cx - cy - wt;
      n[1] = -cx + cy - wt;
      n[2] = cx + cy - wt;
      n[3] = cx - cy - wt;
      vel[0] = muldiv(muldiv(-(av[2] + av[3] - av[0] - av[1]), diam, 4 * 65536), c, 65536);
      vel[1] = muldiv(muldiv(av[1] + av[2] - av[0] - av[3], diam, 4 * 65536), c, 65536);
      vel[2] = muldiv(-(av[0] + av[1] + av[2] + av[3]), diam, 8 * geom);
    end
    for (int k = 0; k < 3; k++) begin
      disp_sum[k] = clip(disp_sum[k] + muldiv(vel[k], t, r));
      acc[k] = t == 0 ? 0 : muldiv(vel[k] - prev_vel[k], r, t);
      prev_vel[k] = vel[k];
    end
    for (int k = 0; k < 4; k++) begin
      res.slot = 2'(k);
      res.wheel_speed = 32'(muldiv(n[k], 2 * 65536, diam));
      res.velocity = k < 3 ? 32'(vel[k]) : '0;
      res.displacement = k < 3 ? 32'(disp_sum[k]) : '0;
      res.acceleration = k < 3 ? 32'(acc[k]) : '0;
      res.last = k == 3;
      expected_results.push_back(res);
    end
  endtask

  // register write over apb, mirrored in the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      cwko_pkg::REG_KIND: chassis_omni = val[0];
      cwko_pkg::REG_MAXX: lim_x = longint'(val[30:0]);
      cwko_pkg::REG_MAXY: lim_y = longint'(val[30:0]);
      cwko_pkg::REG_MAXW: lim_w = longint'(val[30:0]);
      cwko_pkg::REG_DIAM: diam = longint'(val[30:0]);
      cwko_pkg::REG_GEOM: geom = longint'(val[30:0]);
      cwko_pkg::REG_RATE: rate = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  function automatic tick_item_t rand_item();
    tick_item_t it;
    // mostly realistic speeds, sometimes full-range values
    if ($urandom_range(0, 3) == 0) begin
      it.tx = $urandom; it.ty = $urandom; it.tw = $urandom;
      it.rpm0 = 16'($urandom); it.rpm1 = 16'($urandom);
      it.rpm2 = 16'($urandom); it.rpm3 = 16'($urandom);
      it.ticks = 16'($urandom);
    end else begin
      it.tx = $signed($urandom_range(0, 524288)) - 262144;
      it.ty = $signed($urandom_range(0, 524288)) - 262144;
      it.tw = $signed($urandom_range(0, 1048576)) - 524288;
      it.rpm0 = 16'($signed($urandom_range(0, 16000)) - 8000);
      it.rpm1 = 16'($signed($urandom_range(0, 16000)) - 8000);
      it.rpm2 = 16'($signed($urandom_range(0, 16000)) - 8000);
      it.rpm3 = 16'($signed($urandom_range(0, 16000)) - 8000);
      it.ticks = 16'($urandom_range(0, 20));
    end
    return it;
  endfunction

  task automatic queue_and_drain(input int count);
    repeat (count) pending_items.push_back(rand_item());
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_tick(drv);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drv <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
          end else begin
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(0, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls at random in every other run of eight results, plus forced hold-off
  always @(posedge clk) begin
    wheel_result_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item, slot %0d", out_slot);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_slot !== exp_res.slot) begin
            $error("slot exp %0d got %0d", exp_res.slot, out_slot); errors++;
          end
          if (out_wheel_target_speed !== exp_res.wheel_speed) begin
            $error("wheel_target_speed exp %0d got %0d", exp_res.wheel_speed,
                   out_wheel_target_speed); errors++;
          end
          if (out_axis_velocity !== exp_res.velocity) begin
            $error("axis_velocity exp %0d got %0d", exp_res.velocity,
                   out_axis_velocity); errors++;
          end
          if (out_axis_displacement !== exp_res.displacement) begin
            $error("axis_displacement exp %0d got %0d", exp_res.displacement,
                   out_axis_displacement); errors++;
          end
          if (out_axis_acceleration !== exp_res.acceleration) begin
            $error("axis_acceleration exp %0d got %0d", exp_res.acceleration,
                   out_axis_acceleration); errors++;
          end
          if (out_last_result !== exp_res.last) begin
            $error("last_result exp %0d got %0d", exp_res.last, out_last_result);
            errors++;
          end
        end
      end
      out_ready <= !hold_off && (results_seen[3] ? ($urandom_range(0, 2) != 0) : 1'b1);
    end
  end

  // long receiver hold-off so the block backs up
  initial begin
    wait (rst_n);
    wait (items_sent >= 40);
    hold_off = 1'b1;
    repeat (15000) @(posedge clk);
    hold_off = 1'b0;
  end

  // run limit
  initial begin
    #(12 * 5000000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tick_item_t it;
    chassis_omni = 1'b0;
    lim_x = 196608; lim_y = 196608; lim_w = 393216;
    diam = 9830; geom = 52429; rate = 1000;
    for (int k = 0; k < 3; k++) begin
      prev_vel[k] = 0;
      disp_sum[k] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero elapsed time, clamping, saturation
    it = '0; pending_items.push_back(it);
    it = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh8000,
           16'sh7fff, 16'sh8000, 16'hffff};
    pending_items.push_back(it);
    it = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh8000,
           16'sh8000, 16'sh8000, 16'h0000};
    pending_items.push_back(it);
    it = '{32'sh00010000, -32'sh00010000, 32'sh00008000, 16'sd100, -16'sd100,
           16'sd200, -16'sd50, 16'd1};
    pending_items.push_back(it);
    for (int i = 0; i < 6; i++) begin
      it = '{32'sh7fffffff, 32'sh7fffffff, 32'sh0, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'hffff};
      pending_items.push_back(it);
    end
    queue_and_drain(4);

    // omni layout with wide limits and a fast tick rate
    write_reg(cwko_pkg::REG_KIND, 32'd1);
    write_reg(cwko_pkg::REG_MAXX, 32'h7fffffff);
    write_reg(cwko_pkg::REG_MAXY, 32'h7fffffff);
    write_reg(cwko_pkg::REG_MAXW, 32'h7fffffff);
    write_reg(cwko_pkg::REG_RATE, 32'd100000);
    queue_and_drain(50);

    // mecanum with zero limits, smallest wheel and geometry, slowest rate
    write_reg(cwko_pkg::REG_KIND, 32'd0);
    write_reg(cwko_pkg::REG_MAXX, 32'd0);
    write_reg(cwko_pkg::REG_MAXY, 32'd0);
    write_reg(cwko_pkg::REG_MAXW, 32'd0);
    write_reg(cwko_pkg::REG_DIAM, 32'd1);
    write_reg(cwko_pkg::REG_GEOM, 32'd1);
    write_reg(cwko_pkg::REG_RATE, 32'd1);
    queue_and_drain(25);

    // omni with largest wheel and geometry
    write_reg(cwko_pkg::REG_KIND, 32'd1);
    write_reg(cwko_pkg::REG_MAXX, 32'd196608);
    write_reg(cwko_pkg::REG_MAXY, 32'd131072);
    write_reg(cwko_pkg::REG_MAXW, 32'd393216);
    write_reg(cwko_pkg::REG_DIAM, 32'h7fffffff);
    write_reg(cwko_pkg::REG_GEOM, 32'h7fffffff);
    write_reg(cwko_pkg::REG_RATE, 32'd250);
    queue_and_drain(25);

    // back to typical mecanum values
    write_reg(cwko_pkg::REG_KIND, 32'd0);
    write_reg(cwko_pkg::REG_DIAM, 32'd9830);
    write_reg(cwko_pkg::REG_GEOM, 32'd52429);
    write_reg(cwko_pkg::REG_RATE, 32'd1000);
    queue_and_drain(50);

    $display("covered %0d ticks, %0d result items, both wheel layouts", items_sent,
             results_seen);
    $display("register settings at their limits, zero time steps and long stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/cwko_pkg.sv
src/cwko_cfg.sv
src/cwko_scale.sv
src/chassis_wheel_kinematics_odometry.sv
dv/chassis_wheel_kinematics_odometry_tb.sv
